### sv/mplx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mplx_pkg
// shared types and constants of the prefixed label extractor
// ----------------------------------------------------------------------------
package mplx_pkg;

   // marker bytes
   localparam logic [7:0] MK_ARRAY16  = 8'hdc;
   localparam logic [7:0] MK_MAP16    = 8'hde;
   localparam logic [7:0] MK_INT16    = 8'hd1;
   localparam logic [7:0] MK_INT32    = 8'hd2;
   localparam logic [7:0] MK_STR16    = 8'hda;
   localparam logic [7:0] MK_FIXSTR   = 8'ha0;
   localparam logic [7:0] MK_FIXSTR_E = 8'haf;

   // label characters
   localparam logic [7:0] CH_M          = 8'h6d;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CH_I          = 8'h69;
   localparam logic [7:0] CH_D          = 8'h64;

   localparam logic [7:0] HEADER_SKIP_RESET = 8'd39;

   // configuration register indexes
   localparam logic REG_HEADER_SKIP = 1'b0;

   // parse phases
   localparam logic [2:0] PH_MARKER  = 3'd0;
   localparam logic [2:0] PH_FIXED   = 3'd1;
   localparam logic [2:0] PH_LEN_HI  = 3'd2;
   localparam logic [2:0] PH_LEN_LO  = 3'd3;
   localparam logic [2:0] PH_COLLECT = 3'd4;
   localparam logic [2:0] PH_STREAM  = 3'd5;
   localparam logic [2:0] PH_SKIP    = 3'd6;

   // result queue between parser and serialiser
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // group of up to four characters caused by one item
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            label_end;
   } mplx_group_type;

endpackage

`default_nettype wire

### sv/mplx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mplx_front
// byte parser: classifies each item and pushes character groups
// ----------------------------------------------------------------------------
module mplx_front
   import mplx_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic [7:0]     data_byte,
   input  wire logic           file_start,
   input  wire logic [7:0]     header_skip,
   output logic                push,
   output mplx_group_type      push_group
);

   logic [7:0]  header_seen_ff, header_seen_in;
   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  payload_skip_ff, payload_skip_in;
   logic [7:0]  length_upper_ff, length_upper_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [15:0] total_ff, total_in;
   logic [2:0]  held_count_ff, held_count_in;
   logic        short_form_ff, short_form_in;
   logic        id_seen_ff, id_seen_in;
   logic        stopped_ff, stopped_in;
   logic [7:0]  held_ff [4];

   logic        hold_wr;
   logic        open_en;
   logic [15:0] open_len;
   logic [15:0] rem_dec;
   logic [2:0]  cnt_inc;

   always_comb begin
      header_seen_in  = header_seen_ff;
      phase_in        = phase_ff;
      payload_skip_in = payload_skip_ff;
      length_upper_in = length_upper_ff;
      remaining_in    = remaining_ff;
      total_in        = total_ff;
      held_count_in   = held_count_ff;
      short_form_in   = short_form_ff;
      id_seen_in      = id_seen_ff;
      stopped_in      = stopped_ff;
      hold_wr         = 1'b0;
      open_en         = 1'b0;
      open_len        = '0;
      push            = 1'b0;
      push_group      = '0;
      rem_dec         = '0;
      cnt_inc         = '0;

      if (accept) begin
         // a new file clears the whole parse first
         if (file_start) begin
            header_seen_in  = '0;
            phase_in        = PH_MARKER;
            payload_skip_in = '0;
            length_upper_in = '0;
            remaining_in    = '0;
            total_in        = '0;
            held_count_in   = '0;
            short_form_in   = 1'b0;
            id_seen_in      = 1'b0;
            stopped_in      = 1'b0;
         end
         rem_dec = remaining_in - 16'd1;
         cnt_inc = held_count_in + 3'd1;

         if (stopped_in) begin
            // ignore everything until next file
         end else if (header_seen_in < header_skip) begin
            header_seen_in = header_seen_in + 8'd1;
         end else begin
            case (phase_in)
               PH_MARKER: begin
                  if (data_byte == MK_ARRAY16 || data_byte == MK_MAP16 ||
                      data_byte == MK_INT16) begin
                     payload_skip_in = 3'd2;
                     phase_in        = PH_FIXED;
                  end else if (data_byte == MK_INT32) begin
                     payload_skip_in = 3'd4;
                     phase_in        = PH_FIXED;
                  end else if (data_byte inside {[MK_FIXSTR:MK_FIXSTR_E]}) begin
                     short_form_in = 1'b1;
                     open_en       = 1'b1;
                     open_len      = {12'd0, data_byte[3:0]};
                  end else if (data_byte == MK_STR16) begin
                     short_form_in = 1'b0;
                     phase_in      = PH_LEN_HI;
                  end
               end
               PH_FIXED: begin
                  if (payload_skip_in != 3'd0) begin
                     payload_skip_in = payload_skip_in - 3'd1;
                  end
                  if (payload_skip_in == 3'd0) begin
                     phase_in = PH_MARKER;
                  end
               end
               PH_LEN_HI: begin
                  length_upper_in = data_byte;
                  phase_in        = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  open_en  = 1'b1;
                  open_len = {length_upper_in, data_byte};
               end
               PH_COLLECT: begin
                  hold_wr       = 1'b1;
                  held_count_in = cnt_inc;
                  remaining_in  = rem_dec;
                  if (cnt_inc == 3'd2) begin
                     if (held_ff[0] != CH_M || data_byte != CH_UNDERSCORE) begin
                        phase_in = (rem_dec == 16'd0) ? PH_MARKER : PH_SKIP;
                     end else if (!(short_form_in && total_in == 16'd4)) begin
                        push                 = 1'b1;
                        push_group.chars[0]  = held_ff[0];
                        push_group.chars[1]  = data_byte;
                        push_group.last_idx  = 2'd1;
                        push_group.label_end = (rem_dec == 16'd0);
                        phase_in = (rem_dec == 16'd0) ? PH_MARKER : PH_STREAM;
                     end
                  end else if (cnt_inc >= 3'd4) begin
                     phase_in = PH_MARKER;
                     // second "m_id" stops the scan
                     if (held_ff[2] == CH_I && data_byte == CH_D && id_seen_in) begin
                        stopped_in = 1'b1;
                     end else begin
                        if (held_ff[2] == CH_I && data_byte == CH_D) begin
                           id_seen_in = 1'b1;
                        end
                        push                 = 1'b1;
                        push_group.chars[0]  = held_ff[0];
                        push_group.chars[1]  = held_ff[1];
                        push_group.chars[2]  = held_ff[2];
                        push_group.chars[3]  = data_byte;
                        push_group.last_idx  = 2'd3;
                        push_group.label_end = 1'b1;
                     end
                  end
               end
               PH_STREAM: begin
                  remaining_in         = rem_dec;
                  push                 = 1'b1;
                  push_group.chars[0]  = data_byte;
                  push_group.last_idx  = 2'd0;
                  push_group.label_end = (rem_dec == 16'd0);
                  if (rem_dec == 16'd0) begin
                     phase_in = PH_MARKER;
                  end
               end
               default: begin
                  if (remaining_in != 16'd0) begin
                     remaining_in = rem_dec;
                  end
                  if (remaining_in == 16'd0) begin
                     phase_in = PH_MARKER;
                  end
               end
            endcase

            if (open_en) begin
               total_in      = open_len;
               remaining_in  = open_len;
               held_count_in = '0;
               if (open_len == 16'd0) begin
                  phase_in = PH_MARKER;
               end else if (open_len < 16'd3) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_COLLECT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_seen_ff  <= '0;
         phase_ff        <= PH_MARKER;
         payload_skip_ff <= '0;
         length_upper_ff <= '0;
         remaining_ff    <= '0;
         total_ff        <= '0;
         held_count_ff   <= '0;
         short_form_ff   <= 1'b0;
         id_seen_ff      <= 1'b0;
         stopped_ff      <= 1'b0;
      end else begin
         header_seen_ff  <= header_seen_in;
         phase_ff        <= phase_in;
         payload_skip_ff <= payload_skip_in;
         length_upper_ff <= length_upper_in;
         remaining_ff    <= remaining_in;
         total_ff        <= total_in;
         held_count_ff   <= held_count_in;
         short_form_ff   <= short_form_in;
         id_seen_ff      <= id_seen_in;
         stopped_ff      <= stopped_in;
      end
   end

   // held characters, written before read
   always_ff @(posedge clock) begin
      if (hold_wr) begin
         held_ff[held_count_ff[1:0]] <= data_byte;
      end
   end

endmodule

`default_nettype wire

### sv/mplx_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mplx_queue
// short queue of character groups between parser and serialiser
// ----------------------------------------------------------------------------
module mplx_queue
   import mplx_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire mplx_group_type  push_group,
   input  wire logic            pop,
   output logic                 not_empty,
   output logic                 not_full,
   output mplx_group_type       head_group
);

   localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

   mplx_group_type     store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign not_full   = (count_ff != DEPTH_CNT);
   assign head_group = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

`default_nettype wire

### sv/mplx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mplx_back
// serialiser: sends the characters of each group one item at a time
// ----------------------------------------------------------------------------
module mplx_back
   import mplx_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_not_empty,
   input  wire mplx_group_type  q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output logic [7:0]           rsp_label_char,
   output logic                 rsp_label_end
);

   logic           busy_ff, busy_in;
   logic [1:0]     idx_ff, idx_in;
   mplx_group_type grp_ff, grp_in;
   logic           grp_done;

   assign rsp_valid      = busy_ff;
   assign rsp_label_char = grp_ff.chars[idx_ff];
   assign rsp_label_end  = grp_ff.label_end && (idx_ff == grp_ff.last_idx);
   assign grp_done       = busy_ff && rsp_ready && (idx_ff == grp_ff.last_idx);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      grp_in  = grp_ff;
      q_pop   = 1'b0;
      if (!busy_ff || grp_done) begin
         // load next group, or go idle
         busy_in = q_not_empty;
         q_pop   = q_not_empty;
         idx_in  = '0;
         grp_in  = q_head;
      end else if (rsp_ready) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

endmodule

`default_nettype wire

### sv/msgpack_prefixed_label_extractor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msgpack_prefixed_label_extractor_unit
// scans a message-pack style byte stream and emits "m_" prefixed labels
// ----------------------------------------------------------------------------
// One byte is taken per item, and a new item can be taken every cycle while
// the result queue has room. After header_skip leading bytes of each file the
// parser follows markers, skips fixed payloads and non-label strings, and
// passes the characters of strings starting with "m_" to the output, one
// character per result item, with label_end set on the last one. A single
// byte can release up to four characters (a short "m_xx" label is held until
// the "m_id" check); these leave at one per cycle from the serialiser while
// rsp_ready is high, so the output side sets the sustained rate only when
// long runs of such labels occur. A second "m_id" stops the scan until an
// item with file_start set. header_skip (reset 39) is written over the csr
// port at byte address 0 and should be changed only while the block is idle.
// ----------------------------------------------------------------------------
module msgpack_prefixed_label_extractor_unit
   import mplx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input bytes
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_file_start,
   // label characters
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_label_char,
   output logic             rsp_label_end,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [7:0]     header_skip_ff, header_skip_in;
   logic           csr_wr;
   logic           accept;
   logic           push;
   mplx_group_type push_group;
   logic           q_pop;
   logic           q_not_empty;
   logic           q_not_full;
   mplx_group_type q_head;

   // configuration register, byte offset ignored
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_HEADER_SKIP) ? {24'd0, header_skip_ff} : '0;

   always_comb begin
      header_skip_in = header_skip_ff;
      if (csr_wr && csr_paddr[2] == REG_HEADER_SKIP) begin
         header_skip_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= HEADER_SKIP_RESET;
      end else begin
         header_skip_ff <= header_skip_in;
      end
   end

   // an item is taken whenever the queue can hold its group
   assign req_ready = q_not_full;
   assign accept    = req_valid && req_ready;

   mplx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .file_start  (req_file_start),
      .header_skip (header_skip_ff),
      .push        (push),
      .push_group  (push_group)
   );

   mplx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .not_full   (q_not_full),
      .head_group (q_head)
   );

   mplx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_label_char (rsp_label_char),
      .rsp_label_end  (rsp_label_end)
   );

endmodule

`default_nettype wire
